@@ rtl/dsj_pkg.sv @@
// Shared types, character codes and calendar tables for the date-string parser.
package dsj_pkg;

  // Width of the Julian day result field.
  localparam int unsigned JulW = 29;

  // Character codes the parser recognizes.
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  // Calendar constants of the day-number formula.
  localparam int unsigned YearOffsLate  = 4800;
  localparam int unsigned YearOffsEarly = 4799;
  localparam int unsigned JdBias        = 32167;
  localparam int unsigned DaysPerYear   = 365;

  // Reciprocal of 100, exact for operands below 2^21.
  localparam int unsigned Recip100W   = 22;
  localparam int unsigned Recip100    = 2684355;
  localparam int unsigned RecipShift  = 28;

  // Month numbers that matter to the checks.
  localparam logic [3:0] MonthFeb  = 4'd2;
  localparam int unsigned MonthMax = 12;
  localparam int unsigned DayMax   = 31;

  // Field being parsed.
  typedef enum logic [1:0] {
    PhYear  = 2'd0,
    PhMonth = 2'd1,
    PhDay   = 2'd2
  } phase_e;

  // Month, day and early error flag of one finished string.
  typedef struct packed {
    logic       bad;
    logic [3:0] month;
    logic [4:0] day;
  } date_ctl_t;

  // Base length of a month; February is given without the leap day.
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // Month term 7834 * mm / 256 of the day-number formula, with mm shifted
  // so that March opens the year.
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [4:0]  mm;
    logic [17:0] prod;
    if (m > MonthFeb) begin
      mm = {1'b0, m} + 5'd1;
    end else begin
      mm = {1'b0, m} + 5'd13;
    end
    prod = 18'(mm) * 18'd7834;
    return prod[16:8];
  endfunction

endpackage

@@ rtl/dsj_front.sv @@
// Front end: byte-wise parser of year, month and day fields.
module dsj_front
  import dsj_pkg::*;
#(
  parameter int unsigned NUMBER_LIMIT = 999999,
  parameter int unsigned YW           = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      char_i,
  input  logic            last_i,
  output logic            rec_valid_o,
  input  logic            rec_ready_i,
  output logic [YW-1:0]   rec_year_o,
  output date_ctl_t       rec_ctl_o
);

  localparam int unsigned CalcW = YW + 4;

  phase_e        phase_q, phase_d;
  logic [YW-1:0] acc_q, acc_d;
  logic [YW-1:0] year_q, year_d;
  logic [YW-1:0] month_q, month_d;
  logic          seen_q, seen_d;
  logic          dayfin_q, dayfin_d;
  logic          err_q, err_d;

  logic             accept;
  logic             is_digit;
  logic [CalcW-1:0] calc;

  assign in_ready_o = rec_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_digit = (char_i >= CharZero) && (char_i <= CharNine);
  assign calc     = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + CalcW'(char_i[3:0]);

  // Parser step for the byte on the input.
  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    year_d   = year_q;
    month_d  = month_q;
    seen_d   = seen_q;
    dayfin_d = dayfin_q;
    err_d    = err_q;
    if (!err_q && !dayfin_q) begin
      if (is_digit) begin
        if (calc > CalcW'(NUMBER_LIMIT)) begin
          err_d = 1'b1;
        end else begin
          acc_d  = YW'(calc);
          seen_d = 1'b1;
        end
      end else if (!seen_q) begin
        if (char_i != CharSpace) begin
          err_d = 1'b1;
        end
      end else if (phase_q == PhDay) begin
        dayfin_d = 1'b1;
      end else if (char_i == CharDash || char_i == CharSlash) begin
        if (phase_q == PhYear) begin
          year_d  = acc_q;
          phase_d = PhMonth;
        end else begin
          month_d = acc_q;
          phase_d = PhDay;
        end
        acc_d  = '0;
        seen_d = 1'b0;
      end else begin
        err_d = 1'b1;
      end
    end
  end

  // A finished string leaves as one record; month and day range are checked here.
  assign rec_valid_o     = accept && last_i;
  assign rec_year_o      = year_d;
  assign rec_ctl_o.month = month_d[3:0];
  assign rec_ctl_o.day   = acc_d[4:0];
  assign rec_ctl_o.bad   = err_d || (phase_d != PhDay) || !seen_d
                        || (month_d == '0) || (month_d > YW'(MonthMax))
                        || (acc_d == '0) || (acc_d > YW'(DayMax));

  // Parser state; the last byte returns it to the start of a string.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhYear;
      acc_q    <= '0;
      year_q   <= '0;
      month_q  <= '0;
      seen_q   <= 1'b0;
      dayfin_q <= 1'b0;
      err_q    <= 1'b0;
    end else if (accept) begin
      if (last_i) begin
        phase_q  <= PhYear;
        acc_q    <= '0;
        year_q   <= '0;
        month_q  <= '0;
        seen_q   <= 1'b0;
        dayfin_q <= 1'b0;
        err_q    <= 1'b0;
      end else begin
        phase_q  <= phase_d;
        acc_q    <= acc_d;
        year_q   <= year_d;
        month_q  <= month_d;
        seen_q   <= seen_d;
        dayfin_q <= dayfin_d;
        err_q    <= err_d;
      end
    end
  end

endmodule

@@ rtl/dsj_fifo.sv @@
// Short register queue that decouples the parser from the day-number pipeline.
module dsj_fifo #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != CntW'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/dsj_back.sv @@
// Back end: three-stage pipeline for the leap-year check and the Julian day number.
module dsj_back
  import dsj_pkg::*;
#(
  parameter int unsigned YW = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [YW-1:0]    in_year_i,
  input  date_ctl_t        in_ctl_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [JulW-1:0]  out_day_o,
  output logic             out_bad_o
);

  localparam int unsigned YyW   = YW + 1;
  localparam int unsigned ProdW = YyW + Recip100W;
  localparam int unsigned MulW  = YyW + 9;

  logic en;
  logic v1_q, v2_q, v3_q;

  // Stage 1 values.
  logic [YyW-1:0]   yy_s0;
  logic [ProdW-1:0] prod_y, prod_yy;
  logic [YW-1:0]    y1_q;
  logic [YyW-1:0]   yy1_q, yq1_q, yyq1_q;
  logic [MulW-1:0]  yy365_q;
  date_ctl_t        ctl1_q;

  // Stage 2 values.
  logic [YyW-1:0]   yrem_full;
  logic [6:0]       yrem;
  logic             leap;
  logic [4:0]       dmax;
  logic [JulW-1:0]  part1_q, hdiff_q, part2_q;
  logic             bad2_q;

  // Output register.
  logic [JulW-1:0]  day3_q;
  logic             bad3_q;

  // The whole pipeline advances unless a finished result is held.
  assign en         = !v3_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: shifted year, divisions by 100 and the year term.
  assign yy_s0   = (in_ctl_i.month > MonthFeb) ? YyW'(in_year_i) + YyW'(YearOffsLate)
                                               : YyW'(in_year_i) + YyW'(YearOffsEarly);
  assign prod_y  = ProdW'(in_year_i) * ProdW'(Recip100);
  assign prod_yy = ProdW'(yy_s0) * ProdW'(Recip100);

  // Stage 2: leap year, month length and partial sums.
  assign yrem_full = YyW'(y1_q) - ({yq1_q[YyW-7:0], 6'b0} + {yq1_q[YyW-6:0], 5'b0}
                                   + {yq1_q[YyW-3:0], 2'b0});
  assign yrem      = yrem_full[6:0];
  assign leap      = ((y1_q[1:0] == 2'b00) && (yrem != '0))
                  || ((yrem == '0) && (yq1_q[1:0] == 2'b00));
  assign dmax      = month_days(ctl1_q.month) + 5'((ctl1_q.month == MonthFeb) && leap);

  // Valid bits of the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en) begin
      y1_q    <= in_year_i;
      yy1_q   <= yy_s0;
      yq1_q   <= YyW'(prod_y >> RecipShift);
      yyq1_q  <= YyW'(prod_yy >> RecipShift);
      yy365_q <= MulW'(yy_s0) * MulW'(DaysPerYear);
      ctl1_q  <= in_ctl_i;

      part1_q <= JulW'(yy365_q) - JulW'(JdBias) + JulW'(yy1_q >> 2);
      hdiff_q <= JulW'(yyq1_q) - JulW'(yyq1_q >> 2);
      part2_q <= JulW'(month_offset(ctl1_q.month)) + JulW'(ctl1_q.day);
      bad2_q  <= ctl1_q.bad || (ctl1_q.day > dmax);

      day3_q  <= bad2_q ? '0 : part1_q - hdiff_q + part2_q;
      bad3_q  <= bad2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_day_o   = day3_q;
  assign out_bad_o   = bad3_q;

endmodule

@@ rtl/date_string_to_julian_day_top.sv @@
// Top level of the date-string to Julian day number converter.
//
// Bytes of a date string "year-month-day" arrive on the s_ channel, one
// transaction per byte; s_tlast_i marks the final byte of a string. Spaces may
// precede each number, the separator is '-' or '/', and bytes after the day's
// digits are ignored. Every string yields exactly one transaction on the m_
// channel once its last byte is taken: the Julian day number in m_tdata_o and
// the invalid flag in m_tuser_o (the day number is zero when invalid).
// The parser takes one byte per cycle while the queue has room; a finished
// string then passes through the queue and the three-stage day-number pipeline
// (divisions by 100, leap check, final sum).
// A four-entry queue sits between parser and pipeline; when the receiver
// stalls, the pipeline holds its result and the queue fills, and only then
// does s_tready_o drop. After reset the parser waits for the first byte of a
// string and the queue and pipeline are empty.
module date_string_to_julian_day_top
  import dsj_pkg::*;
#(
  parameter int unsigned NUMBER_LIMIT = 999999
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input bytes.
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] char_byte
  input  logic        s_tlast_i,   // last_byte
  // Results.
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // [28:0] julian_day, [31:29] zero
  output logic        m_tuser_o    // invalid
);

  localparam int unsigned YW     = $clog2(NUMBER_LIMIT + 1);
  localparam int unsigned RecW   = YW + $bits(date_ctl_t);
  localparam int unsigned QDepth = 4;

  logic            rec_valid, rec_ready;
  logic [YW-1:0]   rec_year;
  date_ctl_t       rec_ctl;
  logic            q_valid, q_ready;
  logic [RecW-1:0] q_data;
  logic [JulW-1:0] jd;

  // Parser.
  dsj_front #(
    .NUMBER_LIMIT (NUMBER_LIMIT),
    .YW           (YW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid_i),
    .in_ready_o  (s_tready_o),
    .char_i      (s_tdata_i),
    .last_i      (s_tlast_i),
    .rec_valid_o (rec_valid),
    .rec_ready_i (rec_ready),
    .rec_year_o  (rec_year),
    .rec_ctl_o   (rec_ctl)
  );

  // Queue of parsed dates.
  dsj_fifo #(
    .WIDTH (RecW),
    .DEPTH (QDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (rec_valid),
    .wr_ready_o (rec_ready),
    .wr_data_i  ({rec_year, rec_ctl}),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  // Day-number pipeline.
  dsj_back #(
    .YW (YW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_year_i   (q_data[RecW-1:$bits(date_ctl_t)]),
    .in_ctl_i    (date_ctl_t'(q_data[$bits(date_ctl_t)-1:0])),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_day_o   (jd),
    .out_bad_o   (m_tuser_o)
  );

  assign m_tdata_o = 32'(jd);

  // An invalid result carries a zero day number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o) |-> (m_tdata_o == 32'd0))
    else $error("invalid result with nonzero day number");

  // A valid date always gives a nonzero day number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o) |-> (m_tdata_o != 32'd0))
    else $error("valid result with zero day number");

  // A queued date moves into the pipeline whenever the output is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && !m_tvalid_o) |-> q_ready)
    else $error("pipeline stalled with free output");

endmodule
